// ===== src/mqpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mqpfs_pkg
// Shared types and codes of the multi-queue priority server.
// ----------------------------------------------------------------------------
package mqpfs_pkg;

	localparam int LEVEL_W = 4;

	typedef enum logic [1:0] {
		ACT_ARRIVE = 2'd0,
		ACT_SERVE  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_SERVED = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_DONE   = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	// Control broadcast from a queue row to each of its cells.
	typedef struct packed {
		logic               push;
		logic               pop;
		logic [LEVEL_W-1:0] level;
	} cell_ctrl_t;

	// Control from the top level to one queue row.
	typedef struct packed {
		logic               push;
		logic               pop;
		logic               flush;
		logic [LEVEL_W-1:0] level;
	} row_ctrl_t;

	// Status from one queue row to the top level.
	typedef struct packed {
		logic empty;
		logic full;
	} row_stat_t;

endpackage

// ===== src/mqpfs_if.sv =====
// ----------------------------------------------------------------------------
// mqpfs_req_if / mqpfs_rsp_if
// Valid/ready channels for requests and results of the priority server.
// ----------------------------------------------------------------------------
interface mqpfs_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] queue_sel;
	logic [3:0] level;

	modport source (output valid, output action, output queue_sel, output level, input ready);
	modport sink   (input valid, input action, input queue_sel, input level, output ready);
endinterface

interface mqpfs_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] entry_id;

	modport source (output valid, output status, output entry_id, input ready);
	modport sink   (input valid, input status, input entry_id, output ready);
endinterface

// ===== src/mqpfs_cell.sv =====
// ----------------------------------------------------------------------------
// mqpfs_cell
// One slot of a sorted queue row: holds a level and an id and trades them
// with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module mqpfs_cell #(
	parameter int ID_W = 16
) (
	input  logic                                clk,
	input  mqpfs_pkg::cell_ctrl_t               ctrl,
	input  logic                                valid,
	input  logic                                prev_holds,
	input  logic [mqpfs_pkg::LEVEL_W-1:0]       prev_level,
	input  logic [ID_W-1:0]                     prev_id,
	input  logic [mqpfs_pkg::LEVEL_W-1:0]       next_level,
	input  logic [ID_W-1:0]                     next_id,
	input  logic [ID_W-1:0]                     new_id,
	output logic [mqpfs_pkg::LEVEL_W-1:0]       level,
	output logic [ID_W-1:0]                     id,
	output logic                                holds
);

	logic [mqpfs_pkg::LEVEL_W-1:0] level_q;
	logic [ID_W-1:0]               id_q;

	// A new entry always carries the largest id, so it goes behind every
	// entry whose level is at least its own.
	assign holds = valid && (level_q >= ctrl.level);

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (!holds) begin
				if (prev_holds) begin
					level_q <= ctrl.level;
					id_q    <= new_id;
				end else begin
					level_q <= prev_level;
					id_q    <= prev_id;
				end
			end
		end else if (ctrl.pop) begin
			level_q <= next_level;
			id_q    <= next_id;
		end
	end

	assign level = level_q;
	assign id    = id_q;

endmodule

// ===== src/mqpfs_row.sv =====
// ----------------------------------------------------------------------------
// mqpfs_row
// One priority queue: a row of cells kept sorted by level, then by id,
// with the best entry always in the first cell.
// ----------------------------------------------------------------------------
module mqpfs_row #(
	parameter int DEPTH = 256,
	parameter int ID_W  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mqpfs_pkg::row_ctrl_t  ctrl,
	input  logic [ID_W-1:0]       new_id,
	output logic [ID_W-1:0]       head_id,
	output mqpfs_pkg::row_stat_t  stat
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]                occ_q;
	mqpfs_pkg::cell_ctrl_t           cctrl;
	logic [mqpfs_pkg::LEVEL_W-1:0]   lvl [DEPTH];
	logic [ID_W-1:0]                 idv [DEPTH];
	logic                            hold [DEPTH];

	always_comb begin
		cctrl.push  = ctrl.push;
		cctrl.pop   = ctrl.pop;
		cctrl.level = ctrl.level;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                          p_holds;
		logic [mqpfs_pkg::LEVEL_W-1:0] p_level;
		logic [ID_W-1:0]               p_id;
		logic [mqpfs_pkg::LEVEL_W-1:0] n_level;
		logic [ID_W-1:0]               n_id;

		if (i == 0) begin : g_first
			assign p_holds = 1'b1;
			assign p_level = ctrl.level;
			assign p_id    = new_id;
		end else begin : g_mid
			assign p_holds = hold[i-1];
			assign p_level = lvl[i-1];
			assign p_id    = idv[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign n_level = lvl[i];
			assign n_id    = idv[i];
		end else begin : g_inner
			assign n_level = lvl[i+1];
			assign n_id    = idv[i+1];
		end

		mqpfs_cell #(.ID_W(ID_W)) u_cell (
			.clk        (clk),
			.ctrl       (cctrl),
			.valid      (occ_q > CNT_W'(i)),
			.prev_holds (p_holds),
			.prev_level (p_level),
			.prev_id    (p_id),
			.next_level (n_level),
			.next_id    (n_id),
			.new_id     (new_id),
			.level      (lvl[i]),
			.id         (idv[i]),
			.holds      (hold[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctrl.flush) begin
			occ_q <= '0;
		end else if (ctrl.push) begin
			occ_q <= occ_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			occ_q <= occ_q - CNT_W'(1);
		end
	end

	assign head_id    = idv[0];
	assign stat.empty = (occ_q == '0);
	assign stat.full  = (occ_q == CNT_W'(DEPTH));

endmodule

// ===== src/multi_queue_priority_fifo_server.sv =====
// ----------------------------------------------------------------------------
// multi_queue_priority_fifo_server
// Several independent priority queues served highest level first, oldest
// id first among equal levels.
// ----------------------------------------------------------------------------
// Result: registered on its request transfer and presented in the next cycle.
// Throughput: one request per cycle while results are taken; every insert
// or remove is a single parallel shift across the cell row of one queue.
// Reset: all queues empty and the id counter at 1, at once; no clearing pass.
// The unused action code is accepted and produces no result.
module multi_queue_priority_fifo_server #(
	parameter int NUM_QUEUES  = 3,
	parameter int QUEUE_DEPTH = 256,
	parameter int NUM_LEVELS  = 10,
	parameter int ID_WIDTH    = 16
) (
	input logic        clk,
	input logic        arst_n,
	mqpfs_req_if.sink  req,
	mqpfs_rsp_if.source rsp
);

	localparam int LW = mqpfs_pkg::LEVEL_W;

	logic                  acc;
	logic                  q_ok;
	logic [LW-1:0]         lvl_c;
	logic [ID_WIDTH-1:0]   next_id_q;
	logic                  sel_empty;
	logic                  sel_full;
	logic [ID_WIDTH-1:0]   sel_head;
	logic                  do_push;
	logic                  do_pop;
	logic                  do_flush;
	logic                  res_load;
	mqpfs_pkg::status_t    status_d;
	logic [ID_WIDTH-1:0]   id_d;
	logic                  res_valid_q;
	mqpfs_pkg::status_t    status_q;
	logic [15:0]           id_q;

	mqpfs_pkg::row_ctrl_t  rctrl [NUM_QUEUES];
	mqpfs_pkg::row_stat_t  rstat [NUM_QUEUES];
	logic [ID_WIDTH-1:0]   rhead [NUM_QUEUES];

	assign req.ready = !res_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign q_ok      = int'(req.queue_sel) < NUM_QUEUES;

	always_comb begin
		if (req.level == '0) begin
			lvl_c = LW'(1);
		end else if (int'(req.level) > NUM_LEVELS) begin
			lvl_c = LW'(NUM_LEVELS);
		end else begin
			lvl_c = req.level;
		end
	end

	always_comb begin
		sel_empty = 1'b1;
		sel_full  = 1'b1;
		sel_head  = '0;
		for (int r = 0; r < NUM_QUEUES; r++) begin
			if (int'(req.queue_sel) == r) begin
				sel_empty = rstat[r].empty;
				sel_full  = rstat[r].full;
				sel_head  = rhead[r];
			end
		end
	end

	always_comb begin
		do_push  = 1'b0;
		do_pop   = 1'b0;
		do_flush = 1'b0;
		res_load = 1'b1;
		status_d = mqpfs_pkg::ST_DONE;
		id_d     = '0;
		unique case (mqpfs_pkg::action_t'(req.action))
			mqpfs_pkg::ACT_ARRIVE: begin
				if (!q_ok || sel_full || next_id_q == '0) begin
					status_d = mqpfs_pkg::ST_REJECT;
				end else begin
					do_push  = acc;
					status_d = mqpfs_pkg::ST_DONE;
					id_d     = next_id_q;
				end
			end
			mqpfs_pkg::ACT_SERVE: begin
				if (!q_ok || sel_empty) begin
					status_d = mqpfs_pkg::ST_EMPTY;
				end else begin
					do_pop   = acc;
					status_d = mqpfs_pkg::ST_SERVED;
					id_d     = sel_head;
				end
			end
			mqpfs_pkg::ACT_CLEAR: begin
				do_flush = acc;
			end
			mqpfs_pkg::ACT_NONE: begin
				res_load = 1'b0;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	for (genvar r = 0; r < NUM_QUEUES; r++) begin : g_row
		logic hit;

		assign hit = (int'(req.queue_sel) == r);

		always_comb begin
			rctrl[r].push  = do_push && hit;
			rctrl[r].pop   = do_pop && hit;
			rctrl[r].flush = do_flush;
			rctrl[r].level = lvl_c;
		end

		mqpfs_row #(.DEPTH(QUEUE_DEPTH), .ID_W(ID_WIDTH)) u_row (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (rctrl[r]),
			.new_id  (next_id_q),
			.head_id (rhead[r]),
			.stat    (rstat[r])
		);
	end

	// The counter wraps to zero after the last id, which marks it exhausted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= ID_WIDTH'(1);
		end else if (do_flush) begin
			next_id_q <= ID_WIDTH'(1);
		end else if (do_push) begin
			next_id_q <= next_id_q + ID_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc) begin
			res_valid_q <= res_load;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && res_load) begin
			status_q <= status_d;
			id_q     <= 16'(id_d);
		end
	end

	assign rsp.valid    = res_valid_q;
	assign rsp.status   = status_q;
	assign rsp.entry_id = id_q;

	a_clear_restarts_ids: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.action == mqpfs_pkg::ACT_CLEAR |=> next_id_q == ID_WIDTH'(1))
		else $error("id counter not restarted after a clear");

	a_accept_advances_id: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.action == mqpfs_pkg::ACT_ARRIVE && status_d == mqpfs_pkg::ST_DONE
		|=> next_id_q == $past(next_id_q) + ID_WIDTH'(1))
		else $error("accepted arrival did not advance the id counter");

	a_stall_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid)
		else $error("request side stalled with no pending result");

	a_push_pop_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_push && do_pop) && !(do_flush && (do_push || do_pop)))
		else $error("conflicting queue operations in one cycle");

endmodule

// ===== sim/multi_queue_priority_fifo_server_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_queue_priority_fifo_server_tb
// Self-checking bench for the three-queue priority server. Requests are sent
// over the request channel with random gaps. A shadow copy of the queues
// predicts each reply, and every reply transfer is compared with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module multi_queue_priority_fifo_server_tb;

	localparam int NUM_QUEUES    = 3;
	localparam int QUEUE_DEPTH   = 256;
	localparam int NUM_LEVELS    = 10;
	localparam int ID_WIDTH      = 16;
	localparam int LW            = mqpfs_pkg::LEVEL_W;
	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int IDLE_PCT      = 24;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int HOLD_CYCLES   = 400;
	localparam int BURST_PAIRS   = 150;
	localparam int RANDOM_ITEMS  = 860;
	localparam logic [1:0] FILL_QUEUE = 2'd1;

	typedef struct {
		mqpfs_pkg::status_t status;
		logic [15:0]        entry_id;
	} reply_t;

	logic clk;
	logic arst_n;

	mqpfs_req_if req_ch();
	mqpfs_rsp_if rsp_ch();

	multi_queue_priority_fifo_server #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_LEVELS  (NUM_LEVELS),
		.ID_WIDTH    (ID_WIDTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the queue contents.
	logic [LW-1:0]       shadow_level [NUM_QUEUES][QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] shadow_id    [NUM_QUEUES][QUEUE_DEPTH];
	int unsigned         shadow_fill  [NUM_QUEUES];
	logic [ID_WIDTH-1:0] shadow_next_id;

	reply_t      replies_due[$];
	int unsigned fail_count = 0;
	bit          gaps_on = 1'b1;
	int unsigned hold_len = 0;
	int unsigned hold_seq = 0;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	// Applies one request to the shadow queues and works out its reply.
	function automatic void compute_reply(input mqpfs_pkg::action_t act,
			input logic [1:0] qsel, input logic [3:0] lvl, output bit produces,
			output reply_t rep);
		int unsigned q;
		int unsigned best;
		int unsigned last;
		logic [LW-1:0] eff;
		produces = 1'b1;
		rep.status = mqpfs_pkg::ST_DONE;
		rep.entry_id = '0;
		q = qsel;
		case (act)
			mqpfs_pkg::ACT_ARRIVE: begin
				if (q >= NUM_QUEUES || shadow_next_id == 0 ||
						shadow_fill[q] >= QUEUE_DEPTH) begin
					rep.status = mqpfs_pkg::ST_REJECT;
				end else begin
					eff = lvl;
					if (eff < 1)
						eff = LW'(1);
					if (eff > NUM_LEVELS)
						eff = LW'(NUM_LEVELS);
					shadow_level[q][shadow_fill[q]] = eff;
					shadow_id[q][shadow_fill[q]] = shadow_next_id;
					shadow_fill[q]++;
					rep.entry_id = shadow_next_id;
					shadow_next_id++;
				end
			end
			mqpfs_pkg::ACT_SERVE: begin
				if (q >= NUM_QUEUES || shadow_fill[q] == 0) begin
					rep.status = mqpfs_pkg::ST_EMPTY;
				end else begin
					best = 0;
					for (int i = 1; i < shadow_fill[q]; i++) begin
						if (shadow_level[q][i] > shadow_level[q][best] ||
								(shadow_level[q][i] == shadow_level[q][best] &&
								shadow_id[q][i] < shadow_id[q][best]))
							best = i;
					end
					rep.status = mqpfs_pkg::ST_SERVED;
					rep.entry_id = shadow_id[q][best];
					last = shadow_fill[q] - 1;
					shadow_level[q][best] = shadow_level[q][last];
					shadow_id[q][best] = shadow_id[q][last];
					shadow_fill[q] = last;
				end
			end
			mqpfs_pkg::ACT_CLEAR: begin
				for (int i = 0; i < NUM_QUEUES; i++)
					shadow_fill[i] = 0;
				shadow_next_id = ID_WIDTH'(1);
			end
			default: begin
				produces = 1'b0;
			end
		endcase
	endfunction

	// Offers one request after a random gap and waits for its transfer. The
	// valid line is left high so that a following request can go back to back.
	task automatic send_request(input mqpfs_pkg::action_t act, input logic [1:0] qsel,
			input logic [3:0] lvl);
		int unsigned gap;
		bit produces;
		reply_t rep;
		gap = 0;
		while (gaps_on && $urandom_range(99) < IDLE_PCT)
			gap++;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.queue_sel <= qsel;
		req_ch.level <= lvl;
		do
			@(posedge clk);
		while (!req_ch.ready);
		compute_reply(act, qsel, lvl, produces, rep);
		if (produces)
			replies_due.push_back(rep);
	endtask

	task automatic wait_for_replies();
		req_ch.valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Empty queues, out-of-range queue numbers, level clamping, ties among
	// equal levels, the unused action code and a clear.
	task automatic test_directed_cases();
		for (int q = 0; q < 4; q++)
			send_request(mqpfs_pkg::ACT_SERVE, 2'(q), 4'd0);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd3, 4'd5);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd0, 4'd0);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd0, 4'd15);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd0, 4'd10);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd0, 4'd1);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd0, 4'd11);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd0, 4'd7);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd0, 4'd7);
		send_request(mqpfs_pkg::ACT_NONE, 2'd0, 4'd9);
		for (int i = 0; i < 8; i++)
			send_request(mqpfs_pkg::ACT_SERVE, 2'd0, 4'd0);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd1, 4'd4);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd2, 4'd9);
		send_request(mqpfs_pkg::ACT_CLEAR, 2'd1, 4'd0);
		send_request(mqpfs_pkg::ACT_ARRIVE, 2'd2, 4'd3);
		wait_for_replies();
	endtask

	// Fills one queue past the brim while the reply side holds off, so the
	// block has to stall its request side; then drains it in priority order.
	task automatic test_fill_under_backpressure();
		send_request(mqpfs_pkg::ACT_CLEAR, 2'd0, 4'd0);
		hold_len = HOLD_CYCLES;
		hold_seq++;
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			send_request(mqpfs_pkg::ACT_ARRIVE, FILL_QUEUE, 4'($urandom_range(15, 0)));
		send_request(mqpfs_pkg::ACT_NONE, 2'd1, 4'd2);
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			send_request(mqpfs_pkg::ACT_SERVE, FILL_QUEUE, 4'($urandom_range(15, 0)));
		wait_for_replies();
	endtask

	// Arrivals and serves on random queues with no idling on either side.
	task automatic test_back_to_back();
		logic [1:0] qsel;
		gaps_on = 1'b0;
		send_request(mqpfs_pkg::ACT_CLEAR, 2'd0, 4'd0);
		for (int i = 0; i < BURST_PAIRS; i++) begin
			qsel = 2'($urandom_range(NUM_QUEUES - 1, 0));
			send_request(mqpfs_pkg::ACT_ARRIVE, qsel, 4'($urandom_range(15, 0)));
			qsel = 2'($urandom_range(NUM_QUEUES - 1, 0));
			send_request(mqpfs_pkg::ACT_SERVE, qsel, 4'($urandom_range(15, 0)));
		end
		wait_for_replies();
		gaps_on = 1'b1;
	endtask

	// Mixed traffic; the share of arrivals changes every hundred requests so
	// the queues swing between nearly empty and well filled.
	task automatic test_random_traffic();
		int unsigned arrive_pct;
		int unsigned pick;
		mqpfs_pkg::action_t act;
		logic [1:0] qsel;
		arrive_pct = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				arrive_pct = $urandom_range(75, 30);
			pick = $urandom_range(99);
			if (pick < 2)
				act = mqpfs_pkg::ACT_NONE;
			else if (pick < 3)
				act = mqpfs_pkg::ACT_CLEAR;
			else if (pick < 3 + arrive_pct)
				act = mqpfs_pkg::ACT_ARRIVE;
			else
				act = mqpfs_pkg::ACT_SERVE;
			if ($urandom_range(99) < 5)
				qsel = 2'd3;
			else
				qsel = 2'($urandom_range(NUM_QUEUES - 1, 0));
			send_request(act, qsel, 4'($urandom_range(15, 0)));
		end
		wait_for_replies();
	endtask

	// Reply side: random stalls, plus a long hold-off when a test asks for one.
	initial begin : reply_sink
		int unsigned held;
		int unsigned seen_seq;
		held = 0;
		seen_seq = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != seen_seq) begin
				seen_seq = hold_seq;
				held = hold_len;
			end
			if (held != 0) begin
				held--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (replies_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected reply: status %0d entry_id %0d",
						rsp_ch.status, rsp_ch.entry_id);
			end else begin
				want = replies_due.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.entry_id !== want.entry_id) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("reply mismatch: status exp %0d got %0d, entry_id exp %0d got %0d",
							want.status, rsp_ch.status, want.entry_id, rsp_ch.entry_id);
				end
			end
		end
	end

	initial begin : test_sequence
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= mqpfs_pkg::ACT_NONE;
		req_ch.queue_sel <= 2'd0;
		req_ch.level <= 4'd0;
		for (int i = 0; i < NUM_QUEUES; i++)
			shadow_fill[i] = 0;
		shadow_next_id = ID_WIDTH'(1);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_fill_under_backpressure();
		test_back_to_back();
		test_random_traffic();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
